FILE: hdl/ordered_list_shift_engine_top_macros.svh
`ifndef ORDERED_LIST_SHIFT_ENGINE_TOP_MACROS_SVH
`define ORDERED_LIST_SHIFT_ENGINE_TOP_MACROS_SVH

// checked only out of reset
`define OLSE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define OLSE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: hdl/olse_pkg.sv
`timescale 1ns / 1ps

package olse_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 7;
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam logic [3:0] CMD_INS_END   = 4'd0;
    localparam logic [3:0] CMD_INS_FRONT = 4'd1;
    localparam logic [3:0] CMD_INS_POS   = 4'd2;
    localparam logic [3:0] CMD_INS_KEY   = 4'd3;
    localparam logic [3:0] CMD_RM_END    = 4'd4;
    localparam logic [3:0] CMD_RM_FRONT  = 4'd5;
    localparam logic [3:0] CMD_RM_POS    = 4'd6;
    localparam logic [3:0] CMD_RM_KEY    = 4'd7;
    localparam logic [3:0] CMD_RD_POS    = 4'd8;
    localparam logic [3:0] CMD_FIND      = 4'd9;
    localparam logic [3:0] CMD_COUNT     = 4'd10;

    localparam logic [2:0] STAT_OK     = 3'd0;
    localparam logic [2:0] STAT_FULL   = 3'd1;
    localparam logic [2:0] STAT_EMPTY  = 3'd2;
    localparam logic [2:0] STAT_BADPOS = 3'd3;
    localparam logic [2:0] STAT_NOCODE = 3'd4;

    typedef struct packed {
        logic load_new;
        logic take_prev;
        logic take_next;
    } cell_ctrl_t;

endpackage

FILE: hdl/olse_cell.sv
`timescale 1ns / 1ps

module olse_cell
    import olse_pkg::*;
(
    input  logic               aclk,
    input  cell_ctrl_t         ctrl,
    input  logic signed [31:0] prev_code,
    input  logic        [31:0] prev_weight,
    input  logic signed [31:0] next_code,
    input  logic        [31:0] next_weight,
    input  logic signed [31:0] new_code,
    input  logic        [31:0] new_weight,
    input  logic signed [31:0] key_code,
    input  logic               valid,
    output logic signed [31:0] code,
    output logic        [31:0] weight,
    output logic               match
);

    logic signed [31:0] code_reg;
    logic        [31:0] weight_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load_new) begin
            code_reg   <= new_code;
            weight_reg <= new_weight;
        end else if (ctrl.take_prev) begin
            code_reg   <= prev_code;
            weight_reg <= prev_weight;
        end else if (ctrl.take_next) begin
            code_reg   <= next_code;
            weight_reg <= next_weight;
        end
    end

    assign code   = code_reg;
    assign weight = weight_reg;
    assign match  = valid && (code_reg == key_code);

endmodule

FILE: hdl/ordered_list_shift_engine_top.sv
`timescale 1ns / 1ps
// Flow: keys are compared at the transfer edge, and in the execute state cells shift or load
// together while the result is registered and m_valid rises.
// A new command is taken only when idle, after the previous one has executed; the execute
// step waits only while the previous result is not taken.
// Reset: synchronous, active low; clears fill and nonzero counts and handshake state.
// Entry storage is not cleared; no clearing pass, the block is ready right after reset.

module ordered_list_shift_engine_top
    import olse_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic        [3:0]  s_command,
    input  logic signed [31:0] s_key_code,
    input  logic signed [31:0] s_item_code,
    input  logic        [31:0] s_item_weight,
    input  logic        [6:0]  s_position,
    output logic               m_valid,
    input  logic               m_ready,
    output logic        [2:0]  m_status,
    output logic signed [31:0] m_out_code,
    output logic        [31:0] m_out_weight,
    output logic        [6:0]  m_fill_level,
    output logic        [6:0]  m_nonzero_entries,
    output logic               m_is_full,
    output logic               m_is_empty
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    localparam logic [2:0] GE_ALL  = 3'd0;
    localparam logic [2:0] GE_FILL = 3'd1;
    localparam logic [2:0] GE_LAST = 3'd2;
    localparam logic [2:0] GE_POS  = 3'd3;
    localparam logic [2:0] GE_KEY  = 3'd4;

    logic                state_reg, state_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [CNT_W-1:0]    nz_reg, nz_next;
    logic                m_valid_reg, m_valid_next;

    logic [3:0]          cmd_reg;
    logic signed [31:0]  item_code_reg;
    logic        [31:0]  item_weight_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [CAPACITY-1:0] match_reg;

    logic [2:0]          status_reg;
    logic signed [31:0]  out_code_reg;
    logic        [31:0]  out_weight_reg;
    logic [6:0]          fill_out_reg, nz_out_reg;
    logic                full_out_reg, empty_out_reg;

    logic                accept, exec_go;
    logic [CAPACITY-1:0] valid_vec, match_vec, ge, at, key_ge;
    logic signed [31:0]  cell_code [CAPACITY];
    logic        [31:0]  cell_weight [CAPACITY];
    cell_ctrl_t          cell_ctrl [CAPACITY];

    logic [2:0]          status;
    logic [2:0]          ge_sel;
    logic                do_ins, do_rm, do_rd;
    logic                is_full_now, is_empty_now, found, pos_ins_ok, pos_rm_ok;
    logic signed [31:0]  sel_code;
    logic        [31:0]  sel_weight;
    logic                nz_item, nz_sel;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE);
    assign exec_go = (state_reg == S_EXEC) && (!m_valid_reg || m_ready);

    assign is_full_now  = (fill_reg == CNT_W'(CAPACITY));
    assign is_empty_now = (fill_reg == '0);
    assign found        = |match_reg;
    assign pos_ins_ok   = (pos_reg != '0) &&
                          (CMP_W'(pos_reg) <= CMP_W'(fill_reg) + CMP_W'(1));
    assign pos_rm_ok    = (pos_reg != '0) && (CMP_W'(pos_reg) <= CMP_W'(fill_reg));
    // all cells at or above the first match
    assign key_ge       = match_reg | (~match_reg + CAPACITY'(1));

    always_comb begin
        status = STAT_OK;
        do_ins = 1'b0;
        do_rm  = 1'b0;
        do_rd  = 1'b0;
        unique case (cmd_reg) inside
            CMD_INS_END, CMD_INS_FRONT, CMD_INS_POS, CMD_INS_KEY: begin
                if (is_full_now) begin
                    status = STAT_FULL;
                end else if ((cmd_reg == CMD_INS_POS) && !pos_ins_ok) begin
                    status = STAT_BADPOS;
                end else if ((cmd_reg == CMD_INS_KEY) && !found) begin
                    status = STAT_NOCODE;
                end else begin
                    do_ins = 1'b1;
                end
            end
            CMD_RM_END, CMD_RM_FRONT: begin
                if (is_empty_now) begin
                    status = STAT_EMPTY;
                end else begin
                    do_rm = 1'b1;
                end
            end
            CMD_RM_POS, CMD_RD_POS: begin
                if (!pos_rm_ok) begin
                    status = STAT_BADPOS;
                end else begin
                    do_rm = (cmd_reg == CMD_RM_POS);
                    do_rd = (cmd_reg == CMD_RD_POS);
                end
            end
            CMD_RM_KEY, CMD_FIND: begin
                if (!found) begin
                    status = STAT_NOCODE;
                end else begin
                    do_rm = (cmd_reg == CMD_RM_KEY);
                    do_rd = (cmd_reg == CMD_FIND);
                end
            end
            CMD_COUNT: begin
                status = STAT_OK;
            end
            default: begin
                status = STAT_OK;
            end
        endcase
    end

    always_comb begin
        unique case (cmd_reg) inside
            CMD_INS_END:                        ge_sel = GE_FILL;
            CMD_RM_END:                         ge_sel = GE_LAST;
            CMD_INS_POS, CMD_RM_POS, CMD_RD_POS: ge_sel = GE_POS;
            CMD_INS_KEY, CMD_RM_KEY, CMD_FIND:  ge_sel = GE_KEY;
            default:                            ge_sel = GE_ALL;
        endcase
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [31:0] prev_code, next_code;
        logic        [31:0] prev_weight, next_weight;

        assign valid_vec[i] = (CMP_W'(i) < CMP_W'(fill_reg));

        always_comb begin
            case (ge_sel)
                GE_FILL: ge[i] = !valid_vec[i];
                GE_LAST: ge[i] = (CMP_W'(i + 1) >= CMP_W'(fill_reg));
                GE_POS:  ge[i] = (CMP_W'(i + 1) >= CMP_W'(pos_reg));
                GE_KEY:  ge[i] = key_ge[i];
                default: ge[i] = 1'b1;
            endcase
        end

        if (i == 0) begin : g_first
            assign at[i]       = ge[i];
            assign prev_code   = '0;
            assign prev_weight = '0;
        end else begin : g_mid
            assign at[i]       = ge[i] && !ge[i-1];
            assign prev_code   = cell_code[i-1];
            assign prev_weight = cell_weight[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign next_code   = cell_code[i];
            assign next_weight = cell_weight[i];
        end else begin : g_inner
            assign next_code   = cell_code[i+1];
            assign next_weight = cell_weight[i+1];
        end

        assign cell_ctrl[i].load_new  = exec_go && do_ins && at[i];
        assign cell_ctrl[i].take_prev = exec_go && do_ins && ge[i] && !at[i];
        assign cell_ctrl[i].take_next = exec_go && do_rm && ge[i];

        olse_cell u_cell (
            .aclk        (aclk),
            .ctrl        (cell_ctrl[i]),
            .prev_code   (prev_code),
            .prev_weight (prev_weight),
            .next_code   (next_code),
            .next_weight (next_weight),
            .new_code    (item_code_reg),
            .new_weight  (item_weight_reg),
            .key_code    (s_key_code),
            .valid       (valid_vec[i]),
            .code        (cell_code[i]),
            .weight      (cell_weight[i]),
            .match       (match_vec[i])
        );
    end

    always_comb begin
        sel_code   = '0;
        sel_weight = '0;
        for (int j = 0; j < CAPACITY; j++) begin
            if (at[j]) begin
                sel_code   = sel_code | cell_code[j];
                sel_weight = sel_weight | cell_weight[j];
            end
        end
    end

    assign nz_item = (item_code_reg != '0) && (item_weight_reg[30:0] != '0);
    assign nz_sel  = (sel_code != '0) && (sel_weight[30:0] != '0);

    always_comb begin
        fill_next = CNT_W'(fill_reg + CNT_W'(do_ins) - CNT_W'(do_rm));
        nz_next   = CNT_W'(nz_reg + CNT_W'(do_ins && nz_item) - CNT_W'(do_rm && nz_sel));
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (exec_go) begin
                    state_next   = S_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            fill_reg    <= '0;
            nz_reg      <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (exec_go) begin
                fill_reg <= fill_next;
                nz_reg   <= nz_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg         <= s_command;
            item_code_reg   <= s_item_code;
            item_weight_reg <= s_item_weight;
            pos_reg         <= s_position;
            match_reg       <= match_vec;
        end
        if (exec_go) begin
            status_reg     <= status;
            out_code_reg   <= (do_rm || do_rd) ? sel_code : '0;
            out_weight_reg <= (do_rm || do_rd) ? sel_weight : '0;
            fill_out_reg   <= 7'(fill_next);
            nz_out_reg     <= 7'(nz_next);
            full_out_reg   <= (fill_next == CNT_W'(CAPACITY));
            empty_out_reg  <= (fill_next == '0);
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = status_reg;
    assign m_out_code        = out_code_reg;
    assign m_out_weight      = out_weight_reg;
    assign m_fill_level      = fill_out_reg;
    assign m_nonzero_entries = nz_out_reg;
    assign m_is_full         = full_out_reg;
    assign m_is_empty        = empty_out_reg;

endmodule

FILE: hdl/olse_checker.sv
`timescale 1ns / 1ps
`include "ordered_list_shift_engine_top_macros.svh"

module olse_checker
    import olse_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic        [2:0]  m_status,
    input logic signed [31:0] m_out_code,
    input logic        [31:0] m_out_weight,
    input logic        [6:0]  m_fill_level,
    input logic        [6:0]  m_nonzero_entries,
    input logic               m_is_full,
    input logic               m_is_empty
);

    logic [82:0] result_word;
    logic        no_entries;

    assign result_word = {m_status, m_out_code, m_out_weight, m_fill_level,
                          m_nonzero_entries, m_is_full, m_is_empty};
    assign no_entries  = (m_fill_level == '0) && (m_nonzero_entries == '0);

    `OLSE_ASSERT_ALWAYS(a_reset_no_result, !aresetn |=> !m_valid, "result valid after reset")
    `OLSE_ASSERT(a_result_held, m_valid && !m_ready |=> m_valid && $stable(result_word), "result changed")
    `OLSE_ASSERT(a_full_status, m_valid && (m_status == STAT_FULL) |-> m_is_full, "full status, not full")
    `OLSE_ASSERT(a_empty_status, m_valid && (m_status == STAT_EMPTY) |-> m_is_empty, "empty status")
    `OLSE_ASSERT(a_empty_level, m_valid && m_is_empty |-> no_entries, "empty list reports entries")

endmodule

bind ordered_list_shift_engine_top olse_checker u_olse_checker (.*);

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import olse_pkg::*;

    localparam logic [3:0] CMD_UNKNOWN_FIRST = 4'd11;
    localparam logic [3:0] CMD_UNKNOWN_LAST  = 4'd15;
    localparam int         HOLD_CYCLES       = 300;
    localparam int         CYCLE_LIMIT       = 400000;
    localparam int         RANDOM_ITEMS      = 1500;

    localparam int BIAS_GROW   = 0;
    localparam int BIAS_SHRINK = 1;
    localparam int BIAS_MIXED  = 2;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] code;
        logic [31:0] weight;
        logic [6:0]  fill;
        logic [6:0]  nonzero;
        logic        full;
        logic        empty;
    } list_result_t;

    class list_scoreboard;
        logic [31:0]  codes [CAPACITY];
        logic [31:0]  weights [CAPACITY];
        int           count;
        int           errors;
        list_result_t result_q [$];

        function int outstanding();
            return result_q.size();
        endfunction

        function int locate(input logic [31:0] key);
            int i;
            for (i = 0; i < count; i++) begin
                if (codes[i] == key) return i;
            end
            return count;
        endfunction

        function void open_slot(input int at, input logic [31:0] c, input logic [31:0] w);
            int i;
            for (i = count; i > at; i--) begin
                codes[i]   = codes[i - 1];
                weights[i] = weights[i - 1];
            end
            codes[at]   = c;
            weights[at] = w;
            count++;
        endfunction

        function void close_slot(input int at, output logic [31:0] c, output logic [31:0] w);
            int i;
            c = codes[at];
            w = weights[at];
            for (i = at; i + 1 < count; i++) begin
                codes[i]   = codes[i + 1];
                weights[i] = weights[i + 1];
            end
            count--;
        endfunction

        function void note_command(input logic [3:0] cmd, input logic [31:0] key,
                                   input logic [31:0] icode, input logic [31:0] iweight,
                                   input logic [6:0] pos);
            list_result_t r;
            int           k;
            int           i;
            int           nz;
            r        = '0;
            r.status = STAT_OK;
            case (cmd)
                CMD_INS_END, CMD_INS_FRONT, CMD_INS_POS, CMD_INS_KEY: begin
                    if (count >= CAPACITY) begin
                        r.status = STAT_FULL;
                    end else if (cmd == CMD_INS_END) begin
                        open_slot(count, icode, iweight);
                    end else if (cmd == CMD_INS_FRONT) begin
                        open_slot(0, icode, iweight);
                    end else if (cmd == CMD_INS_POS) begin
                        if (pos == 0 || pos > count + 1) r.status = STAT_BADPOS;
                        else open_slot(pos - 1, icode, iweight);
                    end else begin
                        k = locate(key);
                        if (k >= count) r.status = STAT_NOCODE;
                        else open_slot(k, icode, iweight);
                    end
                end
                CMD_RM_END, CMD_RM_FRONT: begin
                    if (count == 0) r.status = STAT_EMPTY;
                    else close_slot((cmd == CMD_RM_END) ? count - 1 : 0, r.code, r.weight);
                end
                CMD_RM_POS, CMD_RD_POS: begin
                    if (pos == 0 || pos > count) begin
                        r.status = STAT_BADPOS;
                    end else if (cmd == CMD_RM_POS) begin
                        close_slot(pos - 1, r.code, r.weight);
                    end else begin
                        r.code   = codes[pos - 1];
                        r.weight = weights[pos - 1];
                    end
                end
                CMD_RM_KEY, CMD_FIND: begin
                    k = locate(key);
                    if (k >= count) begin
                        r.status = STAT_NOCODE;
                    end else if (cmd == CMD_RM_KEY) begin
                        close_slot(k, r.code, r.weight);
                    end else begin
                        r.code   = codes[k];
                        r.weight = weights[k];
                    end
                end
                default: ;
            endcase
            nz = 0;
            for (i = 0; i < count; i++) begin
                if (codes[i] != 0 && weights[i][30:0] != 0) nz++;
            end
            r.fill    = count[6:0];
            r.nonzero = nz[6:0];
            r.full    = (count == CAPACITY);
            r.empty   = (count == 0);
            result_q.push_back(r);
        endfunction

        function void check_field(input string name, input logic [31:0] exp_v,
                                  input logic [31:0] got_v);
            if (got_v !== exp_v) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_result(input list_result_t got);
            list_result_t want;
            if (result_q.size() == 0) begin
                $display("%0t: result transfer with nothing expected", $time);
                errors++;
                return;
            end
            want = result_q.pop_front();
            check_field("status", want.status, got.status);
            check_field("out_code", want.code, got.code);
            check_field("out_weight", want.weight, got.weight);
            check_field("fill_level", want.fill, got.fill);
            check_field("nonzero_entries", want.nonzero, got.nonzero);
            check_field("is_full", want.full, got.full);
            check_field("is_empty", want.empty, got.empty);
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic        [3:0]  s_command;
    logic signed [31:0] s_key_code;
    logic signed [31:0] s_item_code;
    logic        [31:0] s_item_weight;
    logic        [6:0]  s_position;
    logic               m_valid;
    logic               m_ready;
    logic        [2:0]  m_status;
    logic signed [31:0] m_out_code;
    logic        [31:0] m_out_weight;
    logic        [6:0]  m_fill_level;
    logic        [6:0]  m_nonzero_entries;
    logic               m_is_full;
    logic               m_is_empty;

    list_scoreboard sb;
    bit             hold_req;
    int             burst_left;
    int             cycles;

    ordered_list_shift_engine_top dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_key_code        (s_key_code),
        .s_item_code       (s_item_code),
        .s_item_weight     (s_item_weight),
        .s_position        (s_position),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_out_code        (m_out_code),
        .m_out_weight      (m_out_weight),
        .m_fill_level      (m_fill_level),
        .m_nonzero_entries (m_nonzero_entries),
        .m_is_full         (m_is_full),
        .m_is_empty        (m_is_empty)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        list_result_t seen;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                seen = {m_status, m_out_code, m_out_weight, m_fill_level,
                        m_nonzero_entries, m_is_full, m_is_empty};
                sb.check_result(seen);
            end
            if (s_valid && s_ready) begin
                sb.note_command(s_command, s_key_code, s_item_code, s_item_weight, s_position);
            end
        end
    end

    // receiver: changing stall patterns, plus a long hold-off on request
    initial begin
        int mode;
        int span;
        int i;
        m_ready = 1'b0;
        wait (aresetn);
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 300);
            for (i = 0; i < span; i++) begin
                @(negedge aclk);
                if (hold_req) begin
                    hold_req = 1'b0;
                    m_ready  = 1'b0;
                    repeat (HOLD_CYCLES) @(negedge aclk);
                end
                case (mode)
                    0: m_ready = 1'b1;
                    1: m_ready = 1'($urandom_range(0, 1));
                    2: m_ready = ($urandom_range(0, 9) != 0);
                    default: m_ready = ((i % 7) < 3);
                endcase
            end
        end
    end

    task automatic idle(input int n);
        s_valid = 1'b0;
        repeat (n) @(negedge aclk);
    endtask

    task automatic send_item(input logic [3:0] cmd, input logic [31:0] key,
                             input logic [31:0] icode, input logic [31:0] iweight,
                             input logic [6:0] pos);
        s_command     = cmd;
        s_key_code    = key;
        s_item_code   = icode;
        s_item_weight = iweight;
        s_position    = pos;
        s_valid       = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        burst_left--;
        if (burst_left <= 0) begin
            if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 8));
            burst_left = $urandom_range(1, 40);
        end
    endtask

    task automatic drain();
        s_valid = 1'b0;
        while (sb.outstanding() != 0) @(negedge aclk);
    endtask

    function automatic logic [31:0] pick_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return 32'd0;
        if (r < 50) begin
            case ($urandom_range(0, 4))
                0: return 32'd1;
                1: return 32'hFFFF_FFFF;
                2: return 32'h7FFF_FFFF;
                3: return 32'h8000_0000;
                default: return 32'd42;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_weight();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return 32'd0;
        if (r < 25) return 32'h8000_0000;
        if (r < 35) return ($urandom_range(0, 1) != 0) ? 32'h3F80_0000 : 32'h0000_0001;
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60 && sb.count > 0) return sb.codes[$urandom_range(0, sb.count - 1)];
        if (r < 80) return pick_code();
        return $urandom;
    endfunction

    function automatic logic [6:0] pick_position();
        if ($urandom_range(0, 99) < 85) return 7'($urandom_range(0, sb.count + 1));
        return 7'($urandom_range(0, 127));
    endfunction

    function automatic logic [3:0] pick_command(input int bias);
        int r;
        int ins;
        int rm;
        r   = $urandom_range(0, 99);
        ins = (bias == BIAS_GROW) ? 70 : (bias == BIAS_SHRINK) ? 15 : 35;
        rm  = (bias == BIAS_GROW) ? 15 : (bias == BIAS_SHRINK) ? 60 : 35;
        if (r < 3) return 4'($urandom_range(CMD_UNKNOWN_FIRST, CMD_UNKNOWN_LAST));
        if (r < 3 + ins) return 4'($urandom_range(CMD_INS_END, CMD_INS_KEY));
        if (r < 3 + ins + rm) return 4'($urandom_range(CMD_RM_END, CMD_RM_KEY));
        return 4'($urandom_range(CMD_RD_POS, CMD_COUNT));
    endfunction

    // returns 1 when the command code is a known one
    task automatic send_random(input int bias, output bit counted);
        logic [3:0] cmd;
        cmd     = pick_command(bias);
        counted = (cmd <= CMD_COUNT);
        send_item(cmd, pick_key(), pick_code(), pick_weight(), pick_position());
    endtask

    initial begin
        int  done;
        int  phase_len;
        int  bias;
        int  i;
        bit  counted;
        sb            = new();
        hold_req      = 1'b0;
        burst_left    = 1;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_command     = '0;
        s_key_code    = '0;
        s_item_code   = '0;
        s_item_weight = '0;
        s_position    = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // empty list corner cases
        send_item(CMD_COUNT,    32'd0, 32'd0, 32'd0, 7'd0);
        send_item(CMD_RM_END,   32'd0, 32'd0, 32'd0, 7'd0);
        send_item(CMD_RM_FRONT, 32'd0, 32'd0, 32'd0, 7'd0);
        send_item(CMD_RM_POS,   32'd0, 32'd0, 32'd0, 7'd1);
        send_item(CMD_RD_POS,   32'd0, 32'd0, 32'd0, 7'd0);
        send_item(CMD_FIND,     32'd5, 32'd0, 32'd0, 7'd0);
        send_item(CMD_INS_KEY,  32'd5, 32'd9, 32'd1, 7'd0);
        send_item(CMD_INS_POS,  32'd0, 32'd9, 32'd1, 7'd0);
        send_item(CMD_INS_POS,  32'd0, 32'd9, 32'd1, 7'd2);
        // build a short list with extreme values, then read, find and remove entries
        send_item(CMD_INS_END,   32'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 7'd0);
        send_item(CMD_INS_FRONT, 32'd0, 32'h8000_0000, 32'h8000_0000, 7'd0);
        send_item(CMD_INS_POS,   32'd0, 32'd0,         32'd1,         7'd2);
        send_item(CMD_INS_KEY,   32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h3F80_0000, 7'd0);
        send_item(CMD_INS_POS,   32'd0, 32'd3,         32'd0,         7'd5);
        send_item(CMD_RD_POS,    32'd0, 32'd0, 32'd0, 7'd4);
        send_item(CMD_RD_POS,    32'd0, 32'd0, 32'd0, 7'd6);
        send_item(CMD_FIND,      32'hFFFF_FFFF, 32'd0, 32'd0, 7'd0);
        send_item(CMD_RM_KEY,    32'd0, 32'd0, 32'd0, 7'd0);
        send_item(CMD_RM_POS,    32'd0, 32'd0, 32'd0, 7'd127);
        send_item(CMD_UNKNOWN_LAST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd127);
        send_item(CMD_RM_POS,    32'd0, 32'd0, 32'd0, 7'd1);
        send_item(CMD_RM_END,    32'd0, 32'd0, 32'd0, 7'd0);
        send_item(CMD_RM_FRONT,  32'd0, 32'd0, 32'd0, 7'd0);
        send_item(CMD_COUNT,     32'd0, 32'd0, 32'd0, 7'd0);
        drain();

        // receiver holds off while the sender keeps offering transfers
        hold_req = 1'b1;
        for (i = 0; i < 40; i++) send_random(BIAS_GROW, counted);
        drain();

        done = 0;
        while (done < RANDOM_ITEMS) begin
            bias      = $urandom_range(BIAS_GROW, BIAS_MIXED);
            phase_len = $urandom_range(50, 200);
            for (i = 0; i < phase_len && done < RANDOM_ITEMS; i++) begin
                send_random(bias, counted);
                if (counted) done++;
            end
            if ($urandom_range(0, 1) != 0) drain();
        end

        drain();
        repeat (10) @(negedge aclk);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("Simulation PASSED");
        end else begin
            if (sb.outstanding() != 0)
                $display("%0t: %0d results never arrived", $time, sb.outstanding());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
